// ----- rtl/core/tobp_pkg.sv -----
// Shared types and constants for the tree object entry parser.
`timescale 1ns / 1ps
package tobp_pkg;

  localparam int HASH_BYTES = 20;
  localparam int HASH_IDX_W = 5;
  localparam int PATH_IDX_W = 12;
  localparam int MODE_W     = 32;

  localparam logic [HASH_IDX_W-1:0] HASH_LAST = HASH_IDX_W'(HASH_BYTES - 1);
  localparam logic [PATH_IDX_W-1:0] PATH_MAX  = '1;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SEVEN = 8'h37;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  typedef enum logic [2:0] {
    PH_MODE_FIRST = 3'd0,
    PH_MODE       = 3'd1,
    PH_PATH_FIRST = 3'd2,
    PH_PATH       = 3'd3,
    PH_HASH       = 3'd4,
    PH_ERROR      = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    KIND_DIGIT = 3'd0,
    KIND_SPACE = 3'd1,
    KIND_PATH  = 3'd2,
    KIND_NUL   = 3'd3,
    KIND_HASH  = 3'd4,
    KIND_DROP  = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_DIGIT  = 3'd1,
    ST_EMPTY_MODE = 3'd2,
    ST_EMPTY_PATH = 3'd3,
    ST_TRUNCATED  = 3'd4
  } status_t;

  typedef struct packed {
    kind_t                  byte_kind;
    status_t                status;
    logic                   entry_done;
    logic [MODE_W-1:0]      entry_mode;
    logic [PATH_IDX_W-1:0]  path_index;
    logic [HASH_IDX_W-1:0]  hash_index;
  } result_t;

endpackage

// ----- rtl/core/tobp_if.sv -----
// Stream interfaces for object bytes in and parsed results out.
`timescale 1ns / 1ps
interface tobp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_object;

  modport source (output valid, output data_byte, output end_of_object, input ready);
  modport sink (input valid, input data_byte, input end_of_object, output ready);
endinterface

interface tobp_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  byte_kind;
  logic [2:0]  status;
  logic        entry_done;
  logic [31:0] entry_mode;
  logic [11:0] path_index;
  logic [4:0]  hash_index;

  modport source (output valid, output byte_kind, output status, output entry_done,
                  output entry_mode, output path_index, output hash_index, input ready);
  modport sink (input valid, input byte_kind, input status, input entry_done,
                input entry_mode, input path_index, input hash_index, output ready);
endinterface

// ----- rtl/core/tobp_parse.sv -----
// Parser state registers and per-byte classification logic.
`timescale 1ns / 1ps
module tobp_parse (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              end_of_object,
  output tobp_pkg::result_t res
);
  import tobp_pkg::*;

  phase_t                 phase, phase_next;
  logic [MODE_W-1:0]      mode_acc, mode_acc_next;
  logic [PATH_IDX_W-1:0]  path_cnt, path_cnt_next;
  logic [HASH_IDX_W-1:0]  hash_cnt, hash_cnt_next;
  status_t                err_code, err_code_next;

  logic       is_octal;
  logic [2:0] digit;

  assign is_octal = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_SEVEN);
  assign digit    = data_byte[2:0];

  always_comb begin
    phase_next    = phase;
    mode_acc_next = mode_acc;
    path_cnt_next = path_cnt;
    hash_cnt_next = hash_cnt;
    err_code_next = err_code;
    unique case (phase)
      PH_MODE_FIRST: begin
        if (data_byte == CHAR_SPACE) begin
          phase_next    = PH_ERROR;
          err_code_next = ST_EMPTY_MODE;
        end else if (is_octal) begin
          mode_acc_next = MODE_W'(digit);
          phase_next    = PH_MODE;
        end else begin
          phase_next    = PH_ERROR;
          err_code_next = ST_BAD_DIGIT;
        end
      end
      PH_MODE: begin
        if (data_byte == CHAR_SPACE) begin
          phase_next = PH_PATH_FIRST;
        end else if (is_octal) begin
          mode_acc_next = {mode_acc[MODE_W-4:0], 3'b000} + MODE_W'(digit);
        end else begin
          phase_next    = PH_ERROR;
          err_code_next = ST_BAD_DIGIT;
        end
      end
      PH_PATH_FIRST: begin
        if (data_byte == CHAR_NUL) begin
          phase_next    = PH_ERROR;
          err_code_next = ST_EMPTY_PATH;
        end else begin
          path_cnt_next = PATH_IDX_W'(1);
          phase_next    = PH_PATH;
        end
      end
      PH_PATH: begin
        if (data_byte == CHAR_NUL) begin
          hash_cnt_next = '0;
          phase_next    = PH_HASH;
        end else if (path_cnt != PATH_MAX) begin
          path_cnt_next = path_cnt + PATH_IDX_W'(1);
        end
      end
      PH_HASH: begin
        if (hash_cnt == HASH_LAST) begin
          mode_acc_next = '0;
          path_cnt_next = '0;
          hash_cnt_next = '0;
          phase_next    = PH_MODE_FIRST;
        end else begin
          hash_cnt_next = hash_cnt + HASH_IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res = '0;
    res.byte_kind = KIND_DROP;
    unique case (phase) inside
      PH_MODE_FIRST, PH_MODE: begin
        if (phase == PH_MODE && data_byte == CHAR_SPACE) begin
          res.byte_kind = KIND_SPACE;
        end else if (is_octal) begin
          res.byte_kind = KIND_DIGIT;
        end
      end
      PH_PATH_FIRST: begin
        if (data_byte != CHAR_NUL) begin
          res.byte_kind = KIND_PATH;
        end
      end
      PH_PATH: begin
        res.path_index = path_cnt;
        res.byte_kind  = (data_byte == CHAR_NUL) ? KIND_NUL : KIND_PATH;
      end
      PH_HASH: begin
        res.byte_kind  = KIND_HASH;
        res.hash_index = hash_cnt;
        if (hash_cnt == HASH_LAST) begin
          res.entry_done = 1'b1;
          res.entry_mode = mode_acc;
        end
      end
      default: ;
    endcase
    res.status = err_code_next;
    if (end_of_object && err_code_next == ST_OK && phase_next != PH_MODE_FIRST) begin
      res.status = ST_TRUNCATED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_MODE_FIRST;
      mode_acc <= '0;
      path_cnt <= '0;
      hash_cnt <= '0;
      err_code <= ST_OK;
    end else if (accept) begin
      if (end_of_object) begin
        phase    <= PH_MODE_FIRST;
        mode_acc <= '0;
        path_cnt <= '0;
        hash_cnt <= '0;
        err_code <= ST_OK;
      end else begin
        phase    <= phase_next;
        mode_acc <= mode_acc_next;
        path_cnt <= path_cnt_next;
        hash_cnt <= hash_cnt_next;
        err_code <= err_code_next;
      end
    end
  end

endmodule

// ----- rtl/core/tobp_skid.sv -----
// Result register with a skid entry to decouple input and output handshakes.
`timescale 1ns / 1ps
module tobp_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tobp_pkg::result_t push_data,
  output logic              push_ready,
  output logic              pop_valid,
  input  logic              pop_ready,
  output tobp_pkg::result_t pop_data
);
  import tobp_pkg::*;

  result_t main_data, spare_data;
  logic    main_valid, spare_valid;

  assign push_ready = !spare_valid;
  assign pop_valid  = main_valid;
  assign pop_data   = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid  <= 1'b0;
      spare_valid <= 1'b0;
    end else if (!main_valid || pop_ready) begin
      main_valid  <= spare_valid || push;
      spare_valid <= 1'b0;
    end else if (push) begin
      spare_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || pop_ready) begin
      main_data <= spare_valid ? spare_data : push_data;
    end else if (push) begin
      spare_data <= push_data;
    end
  end

endmodule

// ----- rtl/core/tree_object_entry_parser.sv -----
// Top level of the tree object entry parser.
// Each accepted byte's result is registered in the result buffer before it reaches the output.
// Throughput: one byte per cycle while the buffer has room; state updates on accept.
// A two-entry result buffer keeps input flowing for one beat while the output stalls.
// Reset: synchronous, clears parser state to the first mode digit and empties the buffer.
`timescale 1ns / 1ps
module tree_object_entry_parser (
  input logic           clk,
  input logic           rst,
  tobp_byte_if.sink     tree_bytes,
  tobp_result_if.source parsed
);
  import tobp_pkg::*;

  result_t step_res;
  result_t out_res;
  logic    accept;
  logic    buf_ready;

  assign tree_bytes.ready = buf_ready;
  assign accept           = tree_bytes.valid && buf_ready;

  tobp_parse u_parse (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_byte     (tree_bytes.data_byte),
    .end_of_object (tree_bytes.end_of_object),
    .res           (step_res)
  );

  tobp_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_data  (step_res),
    .push_ready (buf_ready),
    .pop_valid  (parsed.valid),
    .pop_ready  (parsed.ready),
    .pop_data   (out_res)
  );

  assign parsed.byte_kind  = out_res.byte_kind;
  assign parsed.status     = out_res.status;
  assign parsed.entry_done = out_res.entry_done;
  assign parsed.entry_mode = out_res.entry_mode;
  assign parsed.path_index = out_res.path_index;
  assign parsed.hash_index = out_res.hash_index;

endmodule

// ----- rtl/core/tobp_checker.sv -----
// Port-level checks for the tree object entry parser, bound to the top level.
`timescale 1ns / 1ps
module tobp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  byte_kind,
  input logic [2:0]  status,
  input logic        entry_done,
  input logic [31:0] entry_mode,
  input logic [11:0] path_index,
  input logic [4:0]  hash_index
);
  import tobp_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_done_on_last_hash: assert property (@(posedge clk) disable iff (rst)
    out_valid && entry_done |-> byte_kind == KIND_HASH && hash_index == HASH_LAST)
    else $error("entry done off the last hash byte");

  a_drop_has_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_kind == KIND_DROP |-> status != ST_OK && status != ST_TRUNCATED)
    else $error("discarded byte without an error code");

  a_mode_only_on_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !entry_done |-> entry_mode == '0)
    else $error("mode reported without entry done");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(byte_kind) && $stable(status)
      && $stable(path_index))
    else $error("stalled result beat changed");

endmodule

bind tree_object_entry_parser tobp_checker u_tobp_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (parsed.valid),
  .out_ready  (parsed.ready),
  .byte_kind  (parsed.byte_kind),
  .status     (parsed.status),
  .entry_done (parsed.entry_done),
  .entry_mode (parsed.entry_mode),
  .path_index (parsed.path_index),
  .hash_index (parsed.hash_index)
);

// ----- dv/tree_object_entry_parser_checker.sv -----
// Checker: predicts the parse result of every accepted byte and compares result beats.
`timescale 1ns / 1ps
module tree_object_entry_parser_checker (
  input  logic   clk,
  input  logic   rst,
  tobp_byte_if   tree_bytes,
  tobp_result_if parsed,
  output int     fail_count,
  output int     pending
);
  import tobp_pkg::*;

  phase_t                 ph;
  status_t                err;
  logic [MODE_W-1:0]      mode_acc;
  logic [PATH_IDX_W-1:0]  path_cnt;
  logic [HASH_IDX_W-1:0]  hash_cnt;
  result_t                expected_q[$];

  function automatic void clear_parse();
    ph       = PH_MODE_FIRST;
    err      = ST_OK;
    mode_acc = '0;
    path_cnt = '0;
    hash_cnt = '0;
  endfunction

  function automatic void enter_fault(input status_t code);
    err = code;
    ph  = PH_ERROR;
  endfunction

  function automatic result_t classify_byte(input logic [7:0] b, input logic last);
    result_t r;
    logic    octal;
    r           = '0;
    r.byte_kind = KIND_DROP;
    octal       = (b >= CHAR_ZERO) && (b <= CHAR_SEVEN);
    case (ph)
      PH_MODE_FIRST: begin
        if (b == CHAR_SPACE) begin
          enter_fault(ST_EMPTY_MODE);
        end else if (octal) begin
          mode_acc    = MODE_W'(b - CHAR_ZERO);
          r.byte_kind = KIND_DIGIT;
          ph          = PH_MODE;
        end else begin
          enter_fault(ST_BAD_DIGIT);
        end
      end
      PH_MODE: begin
        if (b == CHAR_SPACE) begin
          r.byte_kind = KIND_SPACE;
          ph          = PH_PATH_FIRST;
        end else if (octal) begin
          mode_acc    = (mode_acc << 3) + MODE_W'(b - CHAR_ZERO);
          r.byte_kind = KIND_DIGIT;
        end else begin
          enter_fault(ST_BAD_DIGIT);
        end
      end
      PH_PATH_FIRST: begin
        if (b == CHAR_NUL) begin
          enter_fault(ST_EMPTY_PATH);
        end else begin
          r.byte_kind = KIND_PATH;
          path_cnt    = PATH_IDX_W'(1);
          ph          = PH_PATH;
        end
      end
      PH_PATH: begin
        r.path_index = path_cnt;
        if (b == CHAR_NUL) begin
          r.byte_kind = KIND_NUL;
          hash_cnt    = '0;
          ph          = PH_HASH;
        end else begin
          r.byte_kind = KIND_PATH;
          if (path_cnt != PATH_MAX) path_cnt = path_cnt + PATH_IDX_W'(1);
        end
      end
      PH_HASH: begin
        r.byte_kind  = KIND_HASH;
        r.hash_index = hash_cnt;
        if (hash_cnt == HASH_LAST) begin
          r.entry_done = 1'b1;
          r.entry_mode = mode_acc;
          mode_acc     = '0;
          path_cnt     = '0;
          hash_cnt     = '0;
          ph           = PH_MODE_FIRST;
        end else begin
          hash_cnt = hash_cnt + HASH_IDX_W'(1);
        end
      end
      default: r.byte_kind = KIND_DROP;
    endcase
    r.status = err;
    if (last && err == ST_OK && ph != PH_MODE_FIRST) r.status = ST_TRUNCATED;
    if (last) clear_parse();
    return r;
  endfunction

  task automatic flag(input string field, input logic [31:0] want, input logic [31:0] got);
    $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, field, want, got);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
    clear_parse();
  end

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      clear_parse();
      expected_q.delete();
    end else begin
      if (parsed.valid && parsed.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result beat with no byte outstanding, expected none actual kind %0d",
                   $time, parsed.byte_kind);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (parsed.byte_kind !== want.byte_kind)
            flag("byte_kind", 32'(want.byte_kind), 32'(parsed.byte_kind));
          if (parsed.status !== want.status)
            flag("status", 32'(want.status), 32'(parsed.status));
          if (parsed.entry_done !== want.entry_done)
            flag("entry_done", 32'(want.entry_done), 32'(parsed.entry_done));
          if (parsed.entry_mode !== want.entry_mode)
            flag("entry_mode", want.entry_mode, parsed.entry_mode);
          if (parsed.path_index !== want.path_index)
            flag("path_index", 32'(want.path_index), 32'(parsed.path_index));
          if (parsed.hash_index !== want.hash_index)
            flag("hash_index", 32'(want.hash_index), 32'(parsed.hash_index));
        end
      end
      if (tree_bytes.valid && tree_bytes.ready)
        expected_q.push_back(classify_byte(tree_bytes.data_byte, tree_bytes.end_of_object));
    end
    pending = expected_q.size();
  end

endmodule

// ----- dv/tree_object_entry_parser_test.sv -----
// Testbench top: drives tree object bytes, stalls the result side and reports the verdict.
`timescale 1ns / 1ps
module tree_object_entry_parser_test;
  import tobp_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_BYTES = 400;
  localparam int LONG_PATH = 4100;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   cycle_count;
  int   burst_left;
  int   bytes_sent;
  logic [7:0] obj_bytes[$];

  tobp_byte_if   tree_bytes();
  tobp_result_if parsed();

  tree_object_entry_parser u_dut (
    .clk        (clk),
    .rst        (rst),
    .tree_bytes (tree_bytes),
    .parsed     (parsed)
  );

  tree_object_entry_parser_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .tree_bytes (tree_bytes),
    .parsed     (parsed),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        tree_bytes.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    tree_bytes.valid         <= 1'b1;
    tree_bytes.data_byte     <= b;
    tree_bytes.end_of_object <= last;
    do @(posedge clk); while (!tree_bytes.ready);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic send_object();
    for (int i = 0; i < obj_bytes.size(); i++)
      send_byte(obj_bytes[i], i == obj_bytes.size() - 1);
    bytes_sent += obj_bytes.size();
    obj_bytes.delete();
  endtask

  task automatic drain();
    tree_bytes.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  function automatic logic [7:0] hash_byte();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hff;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic add_entry(input int n_digits, input int path_len, output int path_at);
    for (int i = 0; i < n_digits; i++)
      obj_bytes.push_back(CHAR_ZERO + 8'($urandom_range(0, 7)));
    obj_bytes.push_back(CHAR_SPACE);
    path_at = obj_bytes.size();
    for (int i = 0; i < path_len; i++)
      obj_bytes.push_back(8'($urandom_range(1, 255)));
    obj_bytes.push_back(CHAR_NUL);
    for (int i = 0; i < HASH_BYTES; i++)
      obj_bytes.push_back(hash_byte());
  endtask

  initial begin
    int span;
    int stall_pct;
    int elapsed;
    bit held;
    elapsed = 0;
    held    = 1'b0;
    parsed.ready <= 1'b0;
    do @(negedge clk); while (rst);
    forever begin
      if (!held && elapsed > 600) begin
        held = 1'b1;
        parsed.ready <= 1'b0;
        repeat (300) @(negedge clk);
      end
      if ($urandom_range(0, 5) == 0) begin
        stall_pct = 100;
        span      = $urandom_range(1, 6);
      end else begin
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 90);
        span      = $urandom_range(1, 40);
      end
      repeat (span) begin
        parsed.ready <= ($urandom_range(0, 99) >= stall_pct);
        @(negedge clk);
        elapsed++;
      end
    end
  end

  initial begin
    int n_ent;
    int nd;
    int nd0;
    int path_at;
    int path_at0;
    int plen;
    int shape;
    int cut;
    logic [7:0] b;
    rst                      <= 1'b1;
    tree_bytes.valid         <= 1'b0;
    tree_bytes.data_byte     <= 8'h00;
    tree_bytes.end_of_object <= 1'b0;
    burst_left = 0;
    bytes_sent = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    obj_bytes = '{CHAR_SPACE};
    send_object();
    obj_bytes = '{8'h38};
    send_object();
    obj_bytes = '{CHAR_SEVEN, 8'h78};
    send_object();
    obj_bytes = '{8'h31, CHAR_SPACE, CHAR_NUL};
    send_object();
    obj_bytes = '{8'h31, CHAR_SPACE, 8'h61};
    send_object();
    obj_bytes = '{CHAR_ZERO};
    send_object();
    obj_bytes = '{CHAR_ZERO, CHAR_SPACE};
    send_object();
    obj_bytes = '{8'h78, 8'h61, 8'hff};
    send_object();
    drain();

    add_entry(6, LONG_PATH, path_at);
    add_entry(5, 3, path_at);
    send_object();

    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      n_ent = $urandom_range(1, 3);
      for (int e = 0; e < n_ent; e++) begin
        case ($urandom_range(0, 9))
          0:       nd = $urandom_range(11, 12);
          1:       nd = 1;
          default: nd = $urandom_range(5, 6);
        endcase
        plen = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
        add_entry(nd, plen, path_at);
        if (e == 0) begin
          nd0      = nd;
          path_at0 = path_at;
        end
      end
      shape = $urandom_range(0, 9);
      if (shape == 6) begin
        cut = $urandom_range(1, obj_bytes.size() - 1);
        while (obj_bytes.size() > cut) void'(obj_bytes.pop_back());
      end else if (shape == 7) begin
        obj_bytes[$urandom_range(0, obj_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (shape == 8) begin
        case ($urandom_range(0, 2))
          0: obj_bytes[0] = CHAR_SPACE;
          1: obj_bytes[path_at0] = CHAR_NUL;
          default: begin
            do b = 8'($urandom_range(0, 255));
            while ((b >= CHAR_ZERO && b <= CHAR_SEVEN) || b == CHAR_SPACE);
            obj_bytes[$urandom_range(0, nd0 - 1)] = b;
          end
        endcase
      end else if (shape == 9) begin
        obj_bytes.delete();
        repeat ($urandom_range(1, 6)) obj_bytes.push_back(8'($urandom_range(0, 255)));
      end
      send_object();
      if ($urandom_range(0, 7) == 0) drain();
    end

    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/tobp_pkg.sv
rtl/core/tobp_if.sv
rtl/core/tobp_parse.sv
rtl/core/tobp_skid.sv
rtl/core/tree_object_entry_parser.sv
rtl/core/tobp_checker.sv
dv/tree_object_entry_parser_checker.sv
dv/tree_object_entry_parser_test.sv
